FILE: rtl/tccf_pkg.sv
// tccf_pkg: shared codes, widths and item types of the tcp client connection engine
// no dependencies; used by the interfaces and by every module
package tccf_pkg;

    localparam int unsigned CONNECTIONS_DEF = 1024;
    localparam int unsigned TIME_BITS_DEF   = 48;
    localparam int unsigned CONN_W          = 10;
    localparam int unsigned TIME_W          = 48;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HTTP_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_IVL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_MAX   = 3'd4;

    localparam logic [31:0] SYN_IVL_RST = 32'd1000000000;
    localparam logic [3:0]  SYN_MAX_RST = 4'd3;

    // item kinds
    localparam logic [1:0] RQ_OPEN    = 2'd0;
    localparam logic [1:0] RQ_SEGMENT = 2'd1;
    localparam logic [1:0] RQ_TIMER   = 2'd2;
    localparam logic [1:0] RQ_UNUSED  = 2'd3;

    // flag bit positions
    localparam int unsigned FB_FIN = 0;
    localparam int unsigned FB_SYN = 1;
    localparam int unsigned FB_RST = 2;
    localparam int unsigned FB_ACK = 4;

    // connection states
    localparam logic [2:0] CS_CLOSED   = 3'd0;
    localparam logic [2:0] CS_SYN_SENT = 3'd1;
    localparam logic [2:0] CS_EST      = 3'd2;
    localparam logic [2:0] CS_FW1      = 3'd3;
    localparam logic [2:0] CS_FW2      = 3'd4;
    localparam logic [2:0] CS_LAST_ACK = 3'd6;

    // segment kinds to send
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_SYN  = 3'd1;
    localparam logic [2:0] K_ACK  = 3'd2;
    localparam logic [2:0] K_DATA = 3'd3;
    localparam logic [2:0] K_FIN  = 3'd4;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_EST    = 3'd1;
    localparam logic [2:0] EV_RESET  = 3'd2;
    localparam logic [2:0] EV_CLOSED = 3'd3;
    localparam logic [2:0] EV_FAILED = 3'd4;
    localparam logic [2:0] EV_2XX    = 3'd5;
    localparam logic [2:0] EV_OTHER  = 3'd6;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CONN_W-1:0] conn_id;
        logic [31:0]       seg_seq;
        logic [31:0]       seg_ack;
        logic [7:0]        seg_flags;
        logic [15:0]       seg_len;
        logic              resp_end_seen;
        logic              status_2xx;
        logic [31:0]       initial_seq;
        logic [TIME_W-1:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic [CONN_W-1:0] conn_out;
        logic [2:0]        send_kind;
        logic [31:0]       send_seq;
        logic [31:0]       send_ack;
        logic [2:0]        event_res;
        logic              last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic exec;
        logic sel2;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic none;
        logic two;
    } t_sts;

endpackage

FILE: rtl/tccf_if.sv
// tccf_in_if / tccf_out_if: valid-ready channels for input words and result words
// depends on tccf_pkg for field widths
interface tccf_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [tccf_pkg::CONN_W-1:0] conn_id;
    logic [31:0]                 seg_seq;
    logic [31:0]                 seg_ack;
    logic [7:0]                  seg_flags;
    logic [15:0]                 seg_len;
    logic                        resp_end_seen;
    logic                        status_2xx;
    logic [31:0]                 initial_seq;
    logic [tccf_pkg::TIME_W-1:0] time_now;

    modport source (output valid, req_type, conn_id, seg_seq, seg_ack, seg_flags, seg_len,
                    resp_end_seen, status_2xx, initial_seq, time_now, input ready);
    modport sink (input valid, req_type, conn_id, seg_seq, seg_ack, seg_flags, seg_len,
                  resp_end_seen, status_2xx, initial_seq, time_now, output ready);
endinterface

interface tccf_out_if;
    logic                        valid;
    logic                        ready;
    logic [tccf_pkg::CONN_W-1:0] conn_out;
    logic [2:0]                  send_kind;
    logic [31:0]                 send_seq;
    logic [31:0]                 send_ack;
    logic [2:0]                  event_res;
    logic                        last;

    modport source (output valid, conn_out, send_kind, send_seq, send_ack, event_res, last,
                    input ready);
    modport sink (input valid, conn_out, send_kind, send_seq, send_ack, event_res, last,
                  output ready);
endinterface

FILE: rtl/tccf_ctrl.sv
// tccf_ctrl: sequencer of the connection engine (clear sweep, load, execute, deliver)
// depends on tccf_pkg
module tccf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tccf_pkg::t_cmd o_cmd,
    input  tccf_pkg::t_sts i_sts
);
    import tccf_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_OUT1  = 5'b01000,
        S_OUT2  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.none ? S_IDLE : S_OUT1;
            end
            S_OUT1: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = i_sts.two ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2: begin
                o_out_valid = 1'b1;
                o_cmd.sel2  = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

FILE: rtl/tccf_dp.sv
// tccf_dp: configuration registers, connection table memory and per-item update logic
// depends on tccf_pkg; driven by tccf_ctrl commands
module tccf_dp #(
    parameter int unsigned CONNECTIONS = tccf_pkg::CONNECTIONS_DEF,
    parameter int unsigned TIME_BITS   = tccf_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tccf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tccf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  tccf_pkg::t_in_item                  i_item,
    input  tccf_pkg::t_cmd                      i_cmd,
    output tccf_pkg::t_sts                      o_sts,
    output tccf_pkg::t_res                      o_res
);
    import tccf_pkg::*;

    localparam int unsigned IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

    typedef struct packed {
        logic [2:0]           state;
        logic [31:0]          snd_nxt;
        logic [31:0]          snd_una;
        logic [31:0]          rcv_nxt;
        logic [3:0]           retry;
        logic [TIME_BITS-1:0] syn_time;
        logic                 awaiting;
        logic [15:0]          req_done;
    } t_row;

    // configuration
    logic        r_http_en;
    logic [15:0] r_req_len;
    logic [15:0] r_req_limit;
    logic [31:0] r_syn_ivl;
    logic [3:0]  r_syn_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_http_en   <= 1'b0;
            r_req_len   <= '0;
            r_req_limit <= 16'd1;
            r_syn_ivl   <= SYN_IVL_RST;
            r_syn_max   <= SYN_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HTTP_EN:   r_http_en   <= i_cfg_data[0];
                CFG_REQ_LEN:   r_req_len   <= i_cfg_data[15:0];
                CFG_REQ_LIMIT: r_req_limit <= i_cfg_data[15:0];
                CFG_SYN_IVL:   r_syn_ivl   <= i_cfg_data;
                CFG_SYN_MAX:   r_syn_max   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clear sweep counter
    logic [IDX_W-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // item register and table read
    t_in_item r_item;
    t_row     r_row;
    t_row     mem [CONNECTIONS];

    logic [IDX_W-1:0] ld_idx;
    logic [IDX_W-1:0] ex_idx;
    assign ld_idx = IDX_W'({{(17 - CONN_W){1'b0}}, i_item.conn_id});
    assign ex_idx = IDX_W'({{(17 - CONN_W){1'b0}}, r_item.conn_id});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_row  <= mem[ld_idx];
        end
    end

    // update logic
    t_row             nrow;
    t_res             res1, res2;
    logic [1:0]       nres;
    logic             item_ok;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [31:0]      ack_d;
    logic [31:0]      seq_pl;
    logic [15:0]      req_nxt;
    logic             f_fin, f_syn, f_rst, f_ack;

    assign now_t   = TIME_BITS'({{(64 - TIME_W){1'b0}}, r_item.time_now});
    assign elapsed = now_t - r_row.syn_time;
    assign ack_d   = r_item.seg_ack - r_row.snd_una;
    assign seq_pl  = r_item.seg_seq + {16'd0, r_item.seg_len};
    assign req_nxt = r_row.req_done + 16'd1;
    assign f_fin   = r_item.seg_flags[FB_FIN];
    assign f_syn   = r_item.seg_flags[FB_SYN];
    assign f_rst   = r_item.seg_flags[FB_RST];
    assign f_ack   = r_item.seg_flags[FB_ACK];
    assign item_ok = ({7'd0, r_item.conn_id} < 17'(CONNECTIONS))
                     && (r_item.req_type != RQ_UNUSED);

    always_comb begin
        logic more, fin;
        logic [2:0] ev;
        more = 1'b0;
        fin  = 1'b0;
        ev   = EV_NONE;
        nrow = r_row;
        nres = 2'd0;
        res1 = '0;
        res2 = '0;
        res1.conn_out = r_item.conn_id;
        res2.conn_out = r_item.conn_id;
        res2.last     = 1'b1;
        if (item_ok) begin
            unique case (r_item.req_type)
                RQ_OPEN: begin
                    nrow.state    = CS_SYN_SENT;
                    nrow.snd_nxt  = r_item.initial_seq + 32'd1;
                    nrow.snd_una  = r_item.initial_seq;
                    nrow.rcv_nxt  = '0;
                    nrow.retry    = '0;
                    nrow.syn_time = now_t;
                    nrow.awaiting = 1'b0;
                    nrow.req_done = '0;
                    nres          = 2'd1;
                    res1.send_kind = K_SYN;
                    res1.send_seq  = r_item.initial_seq;
                end
                RQ_TIMER: begin
                    if (r_row.state == CS_SYN_SENT && elapsed >= TIME_BITS'(r_syn_ivl)) begin
                        nres = 2'd1;
                        if (r_row.retry >= r_syn_max) begin
                            nrow.state     = CS_CLOSED;
                            res1.event_res = EV_FAILED;
                        end else begin
                            res1.send_kind = K_SYN;
                            res1.send_seq  = r_row.snd_una;
                            res1.send_ack  = r_row.rcv_nxt;
                            nrow.snd_nxt   = r_row.snd_una + 32'd1;
                            nrow.syn_time  = now_t;
                            nrow.retry     = r_row.retry + 4'd1;
                        end
                    end
                end
                RQ_SEGMENT: begin
                    if (f_rst) begin
                        nrow.state     = CS_CLOSED;
                        nres           = 2'd1;
                        res1.event_res = EV_RESET;
                    end else begin
                        unique case (r_row.state) inside
                            CS_SYN_SENT: begin
                                if (f_syn && f_ack && r_item.seg_ack == r_row.snd_nxt) begin
                                    nrow.rcv_nxt   = r_item.seg_seq + 32'd1;
                                    nrow.snd_una   = r_item.seg_ack;
                                    nrow.state     = CS_EST;
                                    nres           = 2'd1;
                                    res1.send_kind = K_ACK;
                                    res1.send_seq  = r_row.snd_nxt;
                                    res1.send_ack  = nrow.rcv_nxt;
                                    res1.event_res = EV_EST;
                                    if (r_http_en && r_req_len != 16'd0) begin
                                        nres           = 2'd2;
                                        res2.send_kind = K_DATA;
                                        res2.send_seq  = r_row.snd_nxt;
                                        res2.send_ack  = nrow.rcv_nxt;
                                        nrow.snd_nxt   = r_row.snd_nxt + {16'd0, r_req_len};
                                        nrow.awaiting  = 1'b1;
                                    end
                                end
                            end
                            CS_EST: begin
                                if (f_fin) begin
                                    nrow.rcv_nxt   = seq_pl + 32'd1;
                                    nres           = 2'd2;
                                    res1.send_kind = K_ACK;
                                    res1.send_seq  = r_row.snd_nxt;
                                    res1.send_ack  = nrow.rcv_nxt;
                                    res2.send_kind = K_FIN;
                                    res2.send_seq  = r_row.snd_nxt;
                                    res2.send_ack  = nrow.rcv_nxt;
                                    nrow.snd_nxt   = r_row.snd_nxt + 32'd1;
                                    nrow.state     = CS_LAST_ACK;
                                end else if (f_ack) begin
                                    if (ack_d != 32'd0 && !ack_d[31]) begin
                                        nrow.snd_una = r_item.seg_ack;
                                    end
                                    if (r_item.seg_len != 16'd0) begin
                                        nrow.rcv_nxt = seq_pl;
                                        if (r_http_en && r_row.awaiting
                                            && r_item.resp_end_seen) begin
                                            ev = r_item.status_2xx ? EV_2XX : EV_OTHER;
                                            nrow.req_done = req_nxt;
                                            if (r_req_limit != 16'd1 && (r_req_limit == 16'd0
                                                || req_nxt < r_req_limit)) begin
                                                more = 1'b1;
                                            end else begin
                                                fin = 1'b1;
                                            end
                                        end
                                        nres           = 2'd1;
                                        res1.send_kind = K_ACK;
                                        res1.send_seq  = r_row.snd_nxt;
                                        res1.send_ack  = seq_pl;
                                        res1.event_res = ev;
                                        res2.send_seq  = r_row.snd_nxt;
                                        res2.send_ack  = seq_pl;
                                        if (more) begin
                                            nres           = 2'd2;
                                            res2.send_kind = K_DATA;
                                            nrow.snd_nxt   = r_row.snd_nxt
                                                             + {16'd0, r_req_len};
                                        end else if (fin) begin
                                            nres           = 2'd2;
                                            res2.send_kind = K_FIN;
                                            nrow.awaiting  = 1'b0;
                                            nrow.snd_nxt   = r_row.snd_nxt + 32'd1;
                                            nrow.state     = CS_FW1;
                                        end
                                    end
                                end
                            end
                            CS_FW1, CS_FW2: begin
                                if (f_fin) begin
                                    nrow.rcv_nxt   = r_item.seg_seq + 32'd1;
                                    if (f_ack && r_row.state == CS_FW1) begin
                                        nrow.snd_una = r_item.seg_ack;
                                    end
                                    nres           = 2'd1;
                                    res1.send_kind = K_ACK;
                                    res1.send_seq  = r_row.snd_nxt;
                                    res1.send_ack  = nrow.rcv_nxt;
                                    res1.event_res = EV_CLOSED;
                                    nrow.state     = CS_CLOSED;
                                end else if (f_ack && r_row.state == CS_FW1) begin
                                    nrow.snd_una = r_item.seg_ack;
                                    nrow.state   = CS_FW2;
                                end
                            end
                            CS_LAST_ACK: begin
                                if (f_ack) begin
                                    nrow.state     = CS_CLOSED;
                                    nres           = 2'd1;
                                    res1.event_res = EV_CLOSED;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
        res1.last = (nres == 2'd1);
    end

    // table write: clear sweep or item write-back
    t_row clr_row;
    always_comb begin
        clr_row       = r_row;
        clr_row.state = CS_CLOSED;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_idx] <= clr_row;
        end else if (i_cmd.exec && item_ok) begin
            mem[ex_idx] <= nrow;
        end
    end

    // result buffer
    t_res r_res1, r_res2;
    logic r_two;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res1 <= res1;
            r_res2 <= res2;
            r_two  <= (nres == 2'd2);
        end
    end

    assign o_sts.clr_done = (r_clr_idx == IDX_W'(CONNECTIONS - 1));
    assign o_sts.none     = (nres == 2'd0);
    assign o_sts.two      = r_two;
    assign o_res          = i_cmd.sel2 ? r_res2 : r_res1;

endmodule

FILE: rtl/tcp_client_connection_fsm.sv
// tcp_client_connection_fsm: top level of the tcp client connection engine
// depends on tccf_pkg, tccf_if, tccf_ctrl and tccf_dp
//
//  channel | dir | handshake          | word
//  i_in    | in  | valid/ready        | req_type .. time_now, one item
//  o_out   | out | valid/ready        | conn_out .. last, one result
//  i_cfg_* | in  | write enable only  | register index and value
//
// an item is loaded, executed and then its result words are delivered in turn
// the single-port connection table sets this order: one read then one write-back per item
// after reset a clearing pass marks every connection closed,
// no item is taken during it
// a stalled output holds the result words; no new item enters until all are taken
module tcp_client_connection_fsm #(
    parameter int unsigned CONNECTIONS = tccf_pkg::CONNECTIONS_DEF,
    parameter int unsigned TIME_BITS   = tccf_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tccf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tccf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tccf_in_if.sink                         i_in,
    tccf_out_if.source                      o_out
);
    import tccf_pkg::*;

    t_cmd     cmd;
    t_sts     sts;
    t_in_item item;
    t_res     res;

    // gather the input word
    assign item.req_type      = i_in.req_type;
    assign item.conn_id       = i_in.conn_id;
    assign item.seg_seq       = i_in.seg_seq;
    assign item.seg_ack       = i_in.seg_ack;
    assign item.seg_flags     = i_in.seg_flags;
    assign item.seg_len       = i_in.seg_len;
    assign item.resp_end_seen = i_in.resp_end_seen;
    assign item.status_2xx    = i_in.status_2xx;
    assign item.initial_seq   = i_in.initial_seq;
    assign item.time_now      = i_in.time_now;

    // sequencer: clear, accept, execute, deliver up to two words
    tccf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // table, registers and update logic
    tccf_dp #(
        .CONNECTIONS (CONNECTIONS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (res)
    );

    // result word out
    assign o_out.conn_out  = res.conn_out;
    assign o_out.send_kind = res.send_kind;
    assign o_out.send_seq  = res.send_seq;
    assign o_out.send_ack  = res.send_ack;
    assign o_out.event_res = res.event_res;
    assign o_out.last      = res.last;

endmodule

FILE: dv/tcp_client_connection_fsm_tb.sv
// testbench for the tcp client connection engine: directed and random items, scoreboard check
// depends on tccf_pkg, tccf_if and the tcp_client_connection_fsm rtl
module tcp_client_connection_fsm_tb;
    import tccf_pkg::*;

    // one expected or observed result word
    typedef struct packed {
        logic [9:0]  conn;
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [2:0]  ev;
        logic        last;
    } t_word;

    // connection table model plus queue of expected result words
    class conn_scoreboard;
        logic [2:0]  st[1024];
        logic [31:0] snd_nxt[1024];
        logic [31:0] snd_una[1024];
        logic [31:0] rcv_nxt[1024];
        logic [3:0]  retries[1024];
        logic [47:0] syn_t[1024];
        logic        awaiting[1024];
        logic [15:0] req_done[1024];
        logic        http_en;
        logic [15:0] req_len;
        logic [15:0] req_lim;
        logic [31:0] syn_ivl;
        logic [3:0]  syn_max;
        t_word       pending[$];
        int          errors;
        int          checked;

        function new();
            http_en = 1'b0; req_len = 16'd0; req_lim = 16'd1;
            syn_ivl = SYN_IVL_RST; syn_max = SYN_MAX_RST;
            foreach (st[i]) st[i] = CS_CLOSED;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_HTTP_EN:   http_en = v[0];
                CFG_REQ_LEN:   req_len = v[15:0];
                CFG_REQ_LIMIT: req_lim = v[15:0];
                CFG_SYN_IVL:   syn_ivl = v;
                CFG_SYN_MAX:   syn_max = v[3:0];
                default: ;
            endcase
        endfunction

        function void push(logic [9:0] c, logic [2:0] k, logic [31:0] s, logic [31:0] a,
                           logic [2:0] e);
            t_word w;
            w = '{conn: c, kind: k, seq: s, ack: a, ev: e, last: 1'b0};
            pending.push_back(w);
        endfunction

        // note an accepted item and queue the words it causes
        function void note_item(t_in_item it);
            logic [9:0]  c;
            logic [7:0]  fl;
            logic [31:0] d;
            logic [2:0]  ev;
            logic        more, fin;
            int          n0;
            c = it.conn_id;
            fl = it.seg_flags;
            n0 = pending.size();
            more = 1'b0; fin = 1'b0; ev = EV_NONE;
            case (it.req_type)
                RQ_OPEN: begin
                    snd_una[c] = it.initial_seq; rcv_nxt[c] = 32'd0; st[c] = CS_SYN_SENT;
                    retries[c] = 4'd0; syn_t[c] = it.time_now; awaiting[c] = 1'b0;
                    req_done[c] = 16'd0;
                    push(c, K_SYN, it.initial_seq, 32'd0, EV_NONE);
                    snd_nxt[c] = it.initial_seq + 32'd1;
                end
                RQ_TIMER: begin
                    if (st[c] == CS_SYN_SENT && 48'(it.time_now - syn_t[c]) >= 48'(syn_ivl)) begin
                        if (retries[c] >= syn_max) begin
                            st[c] = CS_CLOSED;
                            push(c, K_NONE, 32'd0, 32'd0, EV_FAILED);
                        end else begin
                            push(c, K_SYN, snd_una[c], rcv_nxt[c], EV_NONE);
                            snd_nxt[c] = snd_una[c] + 32'd1;
                            syn_t[c] = it.time_now;
                            retries[c] = retries[c] + 4'd1;
                        end
                    end
                end
                RQ_SEGMENT: begin
                    if (fl[FB_RST]) begin
                        st[c] = CS_CLOSED;
                        push(c, K_NONE, 32'd0, 32'd0, EV_RESET);
                    end else case (st[c])
                        CS_SYN_SENT: if (fl[FB_SYN] && fl[FB_ACK] && it.seg_ack == snd_nxt[c]) begin
                            rcv_nxt[c] = it.seg_seq + 32'd1; snd_una[c] = it.seg_ack;
                            st[c] = CS_EST;
                            push(c, K_ACK, snd_nxt[c], rcv_nxt[c], EV_EST);
                            if (http_en && req_len != 16'd0) begin
                                push(c, K_DATA, snd_nxt[c], rcv_nxt[c], EV_NONE);
                                snd_nxt[c] += 32'(req_len);
                                awaiting[c] = 1'b1;
                            end
                        end
                        CS_EST: begin
                            if (fl[FB_FIN]) begin
                                rcv_nxt[c] = it.seg_seq + 32'(it.seg_len) + 32'd1;
                                push(c, K_ACK, snd_nxt[c], rcv_nxt[c], EV_NONE);
                                push(c, K_FIN, snd_nxt[c], rcv_nxt[c], EV_NONE);
                                snd_nxt[c] += 32'd1;
                                st[c] = CS_LAST_ACK;
                            end else if (fl[FB_ACK]) begin
                                d = it.seg_ack - snd_una[c];
                                if (d != 32'd0 && !d[31]) snd_una[c] = it.seg_ack;
                                if (it.seg_len != 16'd0) begin
                                    rcv_nxt[c] = it.seg_seq + 32'(it.seg_len);
                                    if (http_en && awaiting[c] && it.resp_end_seen) begin
                                        ev = it.status_2xx ? EV_2XX : EV_OTHER;
                                        req_done[c] = req_done[c] + 16'd1;
                                        if (req_lim != 16'd1
                                            && (req_lim == 16'd0 || req_done[c] < req_lim))
                                            more = 1'b1;
                                        else
                                            fin = 1'b1;
                                    end
                                    push(c, K_ACK, snd_nxt[c], rcv_nxt[c], ev);
                                    if (more) begin
                                        push(c, K_DATA, snd_nxt[c], rcv_nxt[c], EV_NONE);
                                        snd_nxt[c] += 32'(req_len);
                                    end else if (fin) begin
                                        awaiting[c] = 1'b0;
                                        push(c, K_FIN, snd_nxt[c], rcv_nxt[c], EV_NONE);
                                        snd_nxt[c] += 32'd1;
                                        st[c] = CS_FW1;
                                    end
                                end
                            end
                        end
                        CS_FW1: begin
                            if (fl[FB_FIN] && fl[FB_ACK]) begin
                                rcv_nxt[c] = it.seg_seq + 32'd1; snd_una[c] = it.seg_ack;
                                push(c, K_ACK, snd_nxt[c], rcv_nxt[c], EV_CLOSED);
                                st[c] = CS_CLOSED;
                            end else if (fl[FB_ACK]) begin
                                snd_una[c] = it.seg_ack; st[c] = CS_FW2;
                            end else if (fl[FB_FIN]) begin
                                rcv_nxt[c] = it.seg_seq + 32'd1;
                                push(c, K_ACK, snd_nxt[c], rcv_nxt[c], EV_CLOSED);
                                st[c] = CS_CLOSED;
                            end
                        end
                        CS_FW2: if (fl[FB_FIN]) begin
                            rcv_nxt[c] = it.seg_seq + 32'd1;
                            push(c, K_ACK, snd_nxt[c], rcv_nxt[c], EV_CLOSED);
                            st[c] = CS_CLOSED;
                        end
                        CS_LAST_ACK: if (fl[FB_ACK]) begin
                            st[c] = CS_CLOSED;
                            push(c, K_NONE, 32'd0, 32'd0, EV_CLOSED);
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_word(t_word got);
            t_word w;
            if (pending.size() == 0) begin
                $error("unexpected result word conn %0d kind %0d", got.conn, got.kind);
                errors++;
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.conn !== w.conn) begin
                $error("conn_out exp %0d got %0d", w.conn, got.conn); errors++;
            end
            if (got.kind !== w.kind) begin
                $error("send_kind exp %0d got %0d", w.kind, got.kind); errors++;
            end
            if (got.seq !== w.seq) begin
                $error("send_seq exp %h got %h", w.seq, got.seq); errors++;
            end
            if (got.ack !== w.ack) begin
                $error("send_ack exp %h got %h", w.ack, got.ack); errors++;
            end
            if (got.ev !== w.ev) begin
                $error("event_res exp %0d got %0d", w.ev, got.ev); errors++;
            end
            if (got.last !== w.last) begin
                $error("last exp %0d got %0d", w.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tccf_in_if  in_ch ();
    tccf_out_if out_ch ();

    tcp_client_connection_fsm DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    conn_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int seg_count = 0;
    int timer_count = 0;
    int open_count = 0;

    // focus connections; two of them at the extreme ids 0 and 1023
    logic [9:0] conn_pool[8];
    logic [47:0] clock_now;

    // output sink: ready changes on the falling edge, words sampled on the rising edge
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_word('{conn: out_ch.conn_out, kind: out_ch.send_kind, seq: out_ch.send_seq,
                            ack: out_ch.send_ack, ev: out_ch.event_res, last: out_ch.last});
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #100000000;
        $display("Some tests failed");
        $finish;
    end

    // drives one word from a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either sends again or calls stop_in
    task automatic put_item(t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= it.req_type;
        in_ch.conn_id <= it.conn_id;
        in_ch.seg_seq <= it.seg_seq;
        in_ch.seg_ack <= it.seg_ack;
        in_ch.seg_flags <= it.seg_flags;
        in_ch.seg_len <= it.seg_len;
        in_ch.resp_end_seen <= it.resp_end_seen;
        in_ch.status_2xx <= it.status_2xx;
        in_ch.initial_seq <= it.initial_seq;
        in_ch.time_now <= it.time_now;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // drop valid and move on to the next falling edge
    task automatic stop_in();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every expected word, then for the tail of any word-less item
    task automatic drain();
        stop_in();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    function automatic t_in_item blank_item(logic [1:0] kind, logic [9:0] c);
        t_in_item it;
        it = '0;
        it.req_type = kind;
        it.conn_id = c;
        it.seg_seq = $urandom();
        it.seg_ack = $urandom();
        it.initial_seq = $urandom();
        it.time_now = 48'({$urandom(), $urandom()});
        it.seg_len = 16'($urandom());
        it.resp_end_seen = 1'($urandom());
        it.status_2xx = 1'($urandom());
        return it;
    endfunction

    task automatic send_seg(logic [9:0] c, logic [7:0] fl, logic [31:0] sq, logic [31:0] ak,
                            logic [15:0] plen, logic re, logic ok);
        t_in_item it;
        it = blank_item(RQ_SEGMENT, c);
        it.seg_flags = fl; it.seg_seq = sq; it.seg_ack = ak;
        it.seg_len = plen; it.resp_end_seen = re; it.status_2xx = ok;
        put_item(it);
        seg_count++;
    endtask

    // a well-formed connection life with random content and random noise
    task automatic session(logic [9:0] c);
        t_in_item it;
        logic [31:0] peer;
        int steps;
        it = blank_item(RQ_OPEN, c);
        it.time_now = clock_now;
        put_item(it);
        open_count++;
        // some timer checks, maybe retransmits or a failure
        repeat ($urandom_range(2)) begin
            clock_now += (($urandom_range(3) == 0) ? 48'(sb.syn_ivl) : 48'($urandom_range(50)));
            it = blank_item(RQ_TIMER, c);
            it.time_now = clock_now;
            put_item(it);
            timer_count++;
        end
        peer = $urandom();
        if ($urandom_range(9) == 0)
            send_seg(c, 8'h12, peer, $urandom(), 16'd0, 1'b0, 1'b0);
        send_seg(c, 8'h12 | 8'($urandom_range(1) << 3), peer, sb.snd_nxt[c], 16'd0, 1'b0, 1'b0);
        steps = $urandom_range(6);
        for (int s = 0; s < steps; s++) begin
            case ($urandom_range(9))
                0: send_seg(c, 8'($urandom()), $urandom(), $urandom(), 16'($urandom()),
                            1'($urandom()), 1'($urandom()));
                1: send_seg(c, 8'h10, $urandom(), sb.snd_nxt[c], 16'd0, 1'b0, 1'b0);
                default: send_seg(c, 8'h18, sb.rcv_nxt[c], sb.snd_nxt[c],
                                  16'($urandom_range(1, 1500)), $urandom_range(3) != 0,
                                  1'($urandom_range(1)));
            endcase
        end
        // close: peer fin, our fin acked, or reset
        case ($urandom_range(4))
            0: send_seg(c, 8'h04, $urandom(), $urandom(), 16'd0, 1'b0, 1'b0);
            1: begin
                send_seg(c, 8'h11, sb.rcv_nxt[c], sb.snd_nxt[c], 16'($urandom_range(20)),
                         1'b0, 1'b0);
                send_seg(c, 8'h10, $urandom(), sb.snd_nxt[c], 16'd0, 1'b0, 1'b0);
            end
            default: begin
                send_seg(c, 8'h10, $urandom(), sb.snd_nxt[c], 16'd0, 1'b0, 1'b0);
                send_seg(c, ($urandom_range(1) ? 8'h11 : 8'h01), sb.rcv_nxt[c],
                         sb.snd_nxt[c], 16'd0, 1'b0, 1'b0);
            end
        endcase
    endtask

    initial begin
        t_in_item it;
        int phase_items;
        in_ch.valid = 1'b0;
        in_ch.req_type = '0; in_ch.conn_id = '0; in_ch.seg_seq = '0; in_ch.seg_ack = '0;
        in_ch.seg_flags = '0; in_ch.seg_len = '0; in_ch.resp_end_seen = 1'b0;
        in_ch.status_2xx = 1'b0; in_ch.initial_seq = '0; in_ch.time_now = '0;
        conn_pool = '{10'd0, 10'd1023, 10'd5, 10'd77, 10'd300, 10'd512, 10'd700, 10'd999};
        clock_now = 48'hFFFF_FFFF_FF00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: open/handshake/request/close and the odd corners
        write_reg(CFG_HTTP_EN, 32'd1);
        write_reg(CFG_REQ_LEN, 32'h0000_FFFF);
        write_reg(CFG_REQ_LIMIT, 32'd2);
        write_reg(CFG_SYN_IVL, 32'd100);
        write_reg(CFG_SYN_MAX, 32'd1);
        it = blank_item(RQ_UNUSED, 10'd4);
        put_item(it);                                     // unknown kind ignored
        it = blank_item(RQ_TIMER, 10'd9);
        put_item(it);                                     // timer on closed conn
        send_seg(10'd9, 8'hFF & ~8'h04, '1, '1, '1, 1'b1, 1'b1); // segment on closed conn
        it = blank_item(RQ_OPEN, 10'd1023);
        it.initial_seq = '1; it.time_now = '1;
        put_item(it);
        it = blank_item(RQ_TIMER, 10'd1023);
        it.time_now = 48'd99;                             // wrapped time, retransmit
        put_item(it);
        it.time_now = 48'd300;
        put_item(it);                                     // retries exhausted, failed
        it = blank_item(RQ_OPEN, 10'd0);
        it.initial_seq = 32'hFFFF_FFFF; it.time_now = '0;
        put_item(it);
        put_item(it);                                     // open on busy conn
        send_seg(10'd0, 8'h12, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 1'b0);
        send_seg(10'd0, 8'h18, 32'd0, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b1);
        send_seg(10'd0, 8'h18, 32'd5, 32'd1, 16'd1, 1'b1, 1'b0); // limit reached, fin
        send_seg(10'd0, 8'h11, 32'd9, 32'd0, 16'd0, 1'b0, 1'b0);
        it = blank_item(RQ_OPEN, 10'd1);
        put_item(it);
        send_seg(10'd1, 8'h12, 32'd7, sb.snd_nxt[1], 16'd0, 1'b0, 1'b0);
        send_seg(10'd1, 8'h01, 32'd8, 32'd0, 16'd3, 1'b0, 1'b0);   // passive close
        send_seg(10'd1, 8'h10, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0);
        send_seg(10'd1, 8'h04, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0);   // reset on closed conn
        drain();

        // random phases through several settings and idle mixes
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_HTTP_EN, 32'($urandom_range(3) != 0));
            write_reg(CFG_REQ_LEN, (ph == 1) ? 32'd0 : (ph == 2) ? 32'h0000_FFFF
                                                              : 32'($urandom()));
            write_reg(CFG_REQ_LIMIT, (ph % 4 == 0) ? 32'd0 : (ph == 3) ? 32'h0000_FFFF
                                                                   : 32'($urandom_range(1, 4)));
            write_reg(CFG_SYN_IVL, (ph == 5) ? 32'hFFFF_FFFF : (ph == 6) ? 32'd1
                                                             : 32'($urandom_range(1, 40)));
            write_reg(CFG_SYN_MAX, (ph == 6) ? 32'd0 : (ph == 7) ? 32'd15
                                                     : 32'($urandom_range(3)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            phase_items = items_sent + 165;
            while (items_sent < phase_items) begin
                if ($urandom_range(9) == 0) begin
                    it = blank_item(2'($urandom_range(3)), 10'($urandom()));
                    it.seg_flags = 8'($urandom());
                    put_item(it);
                end else
                    session(conn_pool[$urandom_range(7)]);
                if ($urandom_range(30) == 0) begin
                    stop_in();
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        begin : finish_up
            int guard;
            guard = 0;
            while (sb.pending.size() != 0 && guard < 100000) begin
                @(negedge i_clk); guard++;
            end
            repeat (20) @(negedge i_clk);
            $display("covered %0d items (%0d opens, %0d segments, %0d timer checks)",
                     items_sent, open_count, seg_count, timer_count);
            $display("checked %0d result words over 8 register settings", sb.checked);
            if (sb.errors == 0 && sb.pending.size() == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
            $finish;
        end
    end
endmodule

FILE: files.f
rtl/tccf_pkg.sv
rtl/tccf_if.sv
rtl/tccf_ctrl.sv
rtl/tccf_dp.sv
rtl/tcp_client_connection_fsm.sv
dv/tcp_client_connection_fsm_tb.sv
